/* sv/ncc_pkg.sv */
// ----------------------------------------------------------------------------
// ncc_pkg
// shared constants, mode codes and default centres of the nearest centroid
// classifier with confusion matrix counter
// ----------------------------------------------------------------------------
package ncc_pkg;

    localparam int NUM_CLASSES     = 6;
    localparam int SAMPLE_BITS     = 12;
    localparam int COUNT_BITS      = 16;
    localparam int CLASS_BITS      = $clog2(NUM_CLASSES);
    localparam int NUM_DEFAULTS    = 6;
    localparam int APB_DATA_BITS   = 64;
    localparam int CENTRE_MAX_BITS = 48;
    localparam int QUEUE_DEPTH     = 2;
    localparam int MODE_BITS       = 2;

    typedef logic [MODE_BITS-1:0] mode_t;

    localparam mode_t MODE_CLASSIFY = 2'd0;
    localparam mode_t MODE_CLEAR    = 2'd1;
    localparam mode_t MODE_READ     = 2'd2;

    typedef logic [15:0] axis_t;

    localparam axis_t DEF_X [NUM_DEFAULTS] = '{
        16'd1480, 16'd1457, 16'd1777, 16'd1186, 16'd1476, 16'd1486
    };
    localparam axis_t DEF_Y [NUM_DEFAULTS] = '{
        16'd1502, 16'd1494, 16'd1473, 16'd1475, 16'd1177, 16'd1770
    };
    localparam axis_t DEF_Z [NUM_DEFAULTS] = '{
        16'd1788, 16'd1199, 16'd1492, 16'd1500, 16'd1494, 16'd1468
    };

    // reset value of centre register idx, fields sb bits wide
    function automatic logic [CENTRE_MAX_BITS-1:0] centre_default(input int idx,
                                                                  input int sb);
        logic [CENTRE_MAX_BITS-1:0] mask;
        logic [CENTRE_MAX_BITS-1:0] pk;
        mask = (CENTRE_MAX_BITS'(1) << sb) - CENTRE_MAX_BITS'(1);
        pk   = '0;
        if (idx < NUM_DEFAULTS)
        begin
            pk = (CENTRE_MAX_BITS'(DEF_X[idx]) & mask)
               | ((CENTRE_MAX_BITS'(DEF_Y[idx]) & mask) << sb)
               | ((CENTRE_MAX_BITS'(DEF_Z[idx]) & mask) << (2 * sb));
        end
        return pk;
    endfunction

endpackage

/* sv/ncc_if.sv */
// ----------------------------------------------------------------------------
// ncc_if
// sample and result channels, valid/ready handshake
// ----------------------------------------------------------------------------
interface ncc_sample_if #(
    parameter int SAMPLE_BITS = ncc_pkg::SAMPLE_BITS,
    parameter int CLASS_BITS  = ncc_pkg::CLASS_BITS
);
    logic                   valid;
    logic                   ready;
    ncc_pkg::mode_t         mode;
    logic [SAMPLE_BITS-1:0] sample_x;
    logic [SAMPLE_BITS-1:0] sample_y;
    logic [SAMPLE_BITS-1:0] sample_z;
    logic [CLASS_BITS-1:0]  true_class;
    logic [CLASS_BITS-1:0]  read_column;

    modport source (
        output valid, mode, sample_x, sample_y, sample_z, true_class, read_column,
        input  ready
    );
    modport sink (
        input  valid, mode, sample_x, sample_y, sample_z, true_class, read_column,
        output ready
    );
endinterface

interface ncc_result_if #(
    parameter int CLASS_BITS = ncc_pkg::CLASS_BITS,
    parameter int COUNT_BITS = ncc_pkg::COUNT_BITS
);
    logic                  valid;
    logic                  ready;
    logic [CLASS_BITS-1:0] predicted_class;
    logic [COUNT_BITS-1:0] cell_count;
    logic                  count_saturated;

    modport source (
        output valid, predicted_class, cell_count, count_saturated,
        input  ready
    );
    modport sink (
        input  valid, predicted_class, cell_count, count_saturated,
        output ready
    );
endinterface

/* sv/ncc_regs.sv */
// ----------------------------------------------------------------------------
// ncc_regs
// apb register file holding the cluster centres
// ----------------------------------------------------------------------------
module ncc_regs #(
    parameter int NUM_CLASSES = ncc_pkg::NUM_CLASSES,
    parameter int SAMPLE_BITS = ncc_pkg::SAMPLE_BITS,
    parameter int ADDR_BITS   = $clog2(NUM_CLASSES * 8),
    parameter int CW          = 3 * SAMPLE_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ADDR_BITS-1:0]              paddr,
    input  logic [ncc_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [ncc_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready,
    output logic [NUM_CLASSES*CW-1:0]         centres
);

    localparam int IW = ADDR_BITS - 3;

    logic [CW-1:0] centre_reg [NUM_CLASSES];
    logic [IW-1:0] idx;
    logic          idx_ok;
    logic          wr;

    assign idx    = paddr[ADDR_BITS-1:3];
    assign idx_ok = {1'b0, idx} < (IW + 1)'(NUM_CLASSES);
    assign wr     = psel && penable && pwrite && idx_ok;
    assign pready = 1'b1;
    assign prdata = idx_ok ? ncc_pkg::APB_DATA_BITS'(centre_reg[idx]) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                centre_reg[i] <= CW'(ncc_pkg::centre_default(i, SAMPLE_BITS));
            end
        end
        else if (wr)
        begin
            centre_reg[idx] <= pwdata[CW-1:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            centres[i*CW +: CW] = centre_reg[i];
        end
    end

endmodule

/* sv/ncc_front.sv */
// ----------------------------------------------------------------------------
// ncc_front
// distance pipeline: squares, sums, then one compare stage per later centre
// ----------------------------------------------------------------------------
module ncc_front #(
    parameter int NUM_CLASSES = ncc_pkg::NUM_CLASSES,
    parameter int SAMPLE_BITS = ncc_pkg::SAMPLE_BITS,
    parameter int CB          = $clog2(NUM_CLASSES),
    parameter int CW          = 3 * SAMPLE_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    ncc_sample_if.sink                samples,
    input  logic [NUM_CLASSES*CW-1:0] centres,
    output logic                      f_valid,
    input  logic                      f_ready,
    output ncc_pkg::mode_t            f_mode,
    output logic [CB-1:0]             f_row,
    output logic [CB-1:0]             f_col
);

    localparam int N    = NUM_CLASSES;
    localparam int SB   = SAMPLE_BITS;
    localparam int SQ   = 2 * SB;
    localparam int DW   = SQ + 2;
    localparam int LAST = N;

    logic [LAST:0]  vld_reg;
    ncc_pkg::mode_t mode_reg [LAST+1];
    logic [CB-1:0]  row_reg [LAST+1];
    logic [CB-1:0]  col_reg [LAST+1];
    logic [SQ-1:0]  sq_reg [N][3];
    logic [DW-1:0]  dist_reg [1:LAST][N];
    logic [CB-1:0]  best_reg [1:LAST];
    logic [DW-1:0]  best_dist_reg [1:LAST];

    logic [SQ-1:0]  sq_next [N][3];
    logic [DW-1:0]  dist_next [N];
    logic           adv;

    function automatic logic [SQ-1:0] sq_diff(input logic [SB-1:0] a,
                                              input logic [SB-1:0] b);
        logic [SB-1:0] d;
        d = (a >= b) ? a - b : b - a;
        return SQ'(d) * SQ'(d);
    endfunction

    assign adv           = !vld_reg[LAST] || f_ready;
    assign samples.ready = adv;

    always_comb
    begin
        for (int c = 0; c < N; c++)
        begin
            sq_next[c][0] = sq_diff(samples.sample_x, centres[c*CW +: SB]);
            sq_next[c][1] = sq_diff(samples.sample_y, centres[c*CW+SB +: SB]);
            sq_next[c][2] = sq_diff(samples.sample_z, centres[c*CW+2*SB +: SB]);
        end
    end

    always_comb
    begin
        for (int c = 0; c < N; c++)
        begin
            dist_next[c] = DW'(sq_reg[c][0]) + DW'(sq_reg[c][1]) + DW'(sq_reg[c][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAST-1:0], samples.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode_reg[0] <= samples.mode;
            row_reg[0]  <= samples.true_class;
            col_reg[0]  <= samples.read_column;
            for (int c = 0; c < N; c++)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    sq_reg[c][a] <= sq_next[c][a];
                end
            end
            for (int j = 1; j <= LAST; j++)
            begin
                mode_reg[j] <= mode_reg[j-1];
                row_reg[j]  <= row_reg[j-1];
                col_reg[j]  <= col_reg[j-1];
            end
            dist_reg[1]      <= dist_next;
            best_reg[1]      <= '0;
            best_dist_reg[1] <= dist_next[0];
            // strict compare keeps the lower index on a tie
            for (int j = 2; j <= LAST; j++)
            begin
                dist_reg[j] <= dist_reg[j-1];
                if (dist_reg[j-1][j-1] < best_dist_reg[j-1])
                begin
                    best_reg[j]      <= CB'(j - 1);
                    best_dist_reg[j] <= dist_reg[j-1][j-1];
                end
                else
                begin
                    best_reg[j]      <= best_reg[j-1];
                    best_dist_reg[j] <= best_dist_reg[j-1];
                end
            end
        end
    end

    assign f_valid = vld_reg[LAST];
    assign f_mode  = mode_reg[LAST];
    assign f_row   = row_reg[LAST];
    assign f_col   = (mode_reg[LAST] == ncc_pkg::MODE_CLASSIFY) ? best_reg[LAST]
                                                               : col_reg[LAST];

endmodule

/* sv/ncc_queue.sv */
// ----------------------------------------------------------------------------
// ncc_queue
// small fifo between the distance pipeline and the counter stage
// ----------------------------------------------------------------------------
module ncc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ncc_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [NW-1:0]    fill_reg;
    logic             push;
    logic             pop;

    assign push_ready = fill_reg != NW'(DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* sv/ncc_back.sv */
// ----------------------------------------------------------------------------
// ncc_back
// confusion matrix memory: read, saturating increment, write back, result
// register; live bits give the cleared state at once, with no clearing cycle
// ----------------------------------------------------------------------------
module ncc_back #(
    parameter int NUM_CLASSES = ncc_pkg::NUM_CLASSES,
    parameter int COUNT_BITS  = ncc_pkg::COUNT_BITS,
    parameter int CB          = $clog2(NUM_CLASSES)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_ready,
    input  ncc_pkg::mode_t q_mode,
    input  logic [CB-1:0]  q_row,
    input  logic [CB-1:0]  q_col,
    ncc_result_if.source   results
);

    localparam int N     = NUM_CLASSES;
    localparam int DEPTH = N * N;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = 2 * CB + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [COUNT_BITS-1:0] mem [DEPTH];
    logic [DEPTH-1:0]      live_reg;

    logic                  s1_valid_reg;
    ncc_pkg::mode_t        s1_mode_reg;
    logic [CB-1:0]         s1_col_reg;
    logic [AW-1:0]         s1_addr_reg;
    logic                  s1_hit_reg;
    logic                  s1_fwd_reg;
    logic [COUNT_BITS-1:0] s1_fwd_data_reg;
    logic [COUNT_BITS-1:0] rd_data_reg;

    logic                  o_valid_reg;
    logic [CB-1:0]         o_pred_reg;
    logic [COUNT_BITS-1:0] o_count_reg;
    logic                  o_sat_reg;

    logic [LW-1:0]         lin;
    logic [AW-1:0]         addr_in;
    logic                  hit_in;
    logic                  take;
    logic                  s1_adv;
    logic [COUNT_BITS-1:0] old;
    logic [COUNT_BITS-1:0] inc;
    logic                  wr_en;
    logic                  clr;
    logic [CB-1:0]         pred_next;
    logic [COUNT_BITS-1:0] count_next;
    logic                  sat_next;

    assign lin     = LW'(q_row) * LW'(N) + LW'(q_col);
    assign addr_in = lin[AW-1:0];
    assign hit_in  = ({1'b0, q_row} < (CB + 1)'(N)) && ({1'b0, q_col} < (CB + 1)'(N));

    assign s1_adv  = s1_valid_reg && (!o_valid_reg || results.ready);
    assign q_ready = !s1_valid_reg || s1_adv;
    assign take    = q_valid && q_ready;

    // last write bypasses the memory when it lands in the same cycle as the read
    assign old   = !live_reg[s1_addr_reg] ? '0
                 : (s1_fwd_reg ? s1_fwd_data_reg : rd_data_reg);
    assign inc   = (old == COUNT_MAX) ? old : old + 1'b1;
    assign wr_en = s1_adv && s1_hit_reg && (s1_mode_reg == ncc_pkg::MODE_CLASSIFY);
    assign clr   = s1_adv && (s1_mode_reg == ncc_pkg::MODE_CLEAR);

    always_comb
    begin
        pred_next  = '0;
        count_next = '0;
        sat_next   = 1'b0;
        case (s1_mode_reg)
            ncc_pkg::MODE_CLASSIFY:
            begin
                pred_next = s1_col_reg;
                if (s1_hit_reg)
                begin
                    count_next = inc;
                    sat_next   = inc == COUNT_MAX;
                end
            end
            ncc_pkg::MODE_READ:
            begin
                if (s1_hit_reg)
                begin
                    count_next = old;
                    sat_next   = old == COUNT_MAX;
                end
            end
            default:
            begin
                pred_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[s1_addr_reg] <= inc;
        end
        if (take)
        begin
            rd_data_reg <= mem[addr_in];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg     <= '0;
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clr)
            begin
                live_reg <= '0;
            end
            else if (wr_en)
            begin
                live_reg[s1_addr_reg] <= 1'b1;
            end
            if (take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_mode_reg     <= q_mode;
            s1_col_reg      <= q_col;
            s1_addr_reg     <= addr_in;
            s1_hit_reg      <= hit_in;
            s1_fwd_reg      <= wr_en && (s1_addr_reg == addr_in);
            s1_fwd_data_reg <= inc;
        end
        if (s1_adv)
        begin
            o_pred_reg  <= pred_next;
            o_count_reg <= count_next;
            o_sat_reg   <= sat_next;
        end
    end

    assign results.valid           = o_valid_reg;
    assign results.predicted_class = o_pred_reg;
    assign results.cell_count      = o_count_reg;
    assign results.count_saturated = o_sat_reg;

endmodule

/* sv/nearest_centroid_confusion_counter_top.sv */
// ----------------------------------------------------------------------------
// nearest_centroid_confusion_counter_top
// nearest centroid classifier over six centres with a saturating
// confusion matrix counter, clear and cell read
//
// channel   dir  handshake      payload
// samples   in   valid/ready    mode, sample_x/y/z, true_class, read_column
// results   out  valid/ready    predicted_class, cell_count, count_saturated
// apb       in   psel/penable   centre registers at 8*i, 64-bit data
//
// one word per cycle sustained while results are taken; NUM_CLASSES+1 front
// stages, queue, then two counter stages (read, update and result register)
// the counter update path is a single memory read/write with bypass
// reset clears the matrix at once through live bits, no clearing pass
// a stalled result stops the counter stage, the queue absorbs the front
// ----------------------------------------------------------------------------
module nearest_centroid_confusion_counter_top #(
    parameter int NUM_CLASSES = ncc_pkg::NUM_CLASSES,
    parameter int SAMPLE_BITS = ncc_pkg::SAMPLE_BITS,
    parameter int COUNT_BITS  = ncc_pkg::COUNT_BITS,
    parameter int CB          = $clog2(NUM_CLASSES),
    parameter int ADDR_BITS   = $clog2(NUM_CLASSES * 8)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    ncc_sample_if.sink                        samples,
    ncc_result_if.source                      results,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ADDR_BITS-1:0]              paddr,
    input  logic [ncc_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [ncc_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready
);

    localparam int CW = 3 * SAMPLE_BITS;
    localparam int QW = ncc_pkg::MODE_BITS + 2 * CB;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [NUM_CLASSES*CW-1:0] centres;
    logic                      f_valid;
    logic                      f_ready;
    ncc_pkg::mode_t            f_mode;
    logic [CB-1:0]             f_row;
    logic [CB-1:0]             f_col;
    logic                      q_valid;
    logic                      q_ready;
    logic [QW-1:0]             q_data;
    ncc_pkg::mode_t            q_mode;
    logic [CB-1:0]             q_row;
    logic [CB-1:0]             q_col;

    ncc_regs #(
        .NUM_CLASSES (NUM_CLASSES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ADDR_BITS   (ADDR_BITS),
        .CW          (CW)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .centres (centres)
    );

    ncc_front #(
        .NUM_CLASSES (NUM_CLASSES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CB          (CB),
        .CW          (CW)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .centres (centres),
        .f_valid (f_valid),
        .f_ready (f_ready),
        .f_mode  (f_mode),
        .f_row   (f_row),
        .f_col   (f_col)
    );

    ncc_queue #(
        .WIDTH (QW),
        .DEPTH (ncc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_mode, f_row, f_col}),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    assign {q_mode, q_row, q_col} = q_data;

    ncc_back #(
        .NUM_CLASSES (NUM_CLASSES),
        .COUNT_BITS  (COUNT_BITS),
        .CB          (CB)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_mode  (q_mode),
        .q_row   (q_row),
        .q_col   (q_col),
        .results (results)
    );

    a_pred_range: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> ({1'b0, results.predicted_class} < (CB + 1)'(NUM_CLASSES)))
        else $error("predicted class beyond centre count");

    a_sat_count: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.count_saturated |-> results.cell_count == COUNT_MAX)
        else $error("saturation flag without full count");

    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid && !f_ready |=> f_valid && $stable(f_mode) && $stable(f_row)
                                && $stable(f_col))
        else $error("front word lost while queue full");

    a_queue_hold: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && !q_ready |=> q_valid && $stable(q_data))
        else $error("queue word lost while counter stage stalled");

endmodule
